// ----- hdl/sca_pkg.sv -----
`default_nettype none
package sca_pkg;

  localparam int SUBSTEP_US_DEF = 4167;
  localparam int MAX_DT_US_DEF  = 10000000;
  localparam int US_PER_S       = 1000000;

  localparam int DIV_NW = 66;
  localparam int DIV_DW = 48;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  localparam logic [30:0] MASS_FLOOR = 31'd7;
  localparam logic [DIV_NW-1:0] ACC_CAP = DIV_NW'(1) << 62;

  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_ANIMATE  = 3'd1;
  localparam logic [2:0] CMD_RETARGET = 3'd2;
  localparam logic [2:0] CMD_SET      = 3'd3;
  localparam logic [2:0] CMD_STOP     = 3'd4;

  localparam logic [2:0] REG_MASS      = 3'd0;
  localparam logic [2:0] REG_STIFFNESS = 3'd1;
  localparam logic [2:0] REG_DAMPING   = 3'd2;
  localparam logic [2:0] REG_VLIMIT    = 3'd3;
  localparam logic [2:0] REG_POS_EPS   = 3'd4;
  localparam logic [2:0] REG_VEL_EPS   = 3'd5;
  localparam logic [2:0] REG_START_VEL = 3'd6;

  typedef enum logic [4:0] {
    S_IDLE, S_CNT, S_CNTW, S_SCL, S_HQ, S_HQW, S_KE, S_CV, S_F, S_ADIV,
    S_AHH, S_AHL, S_VUPD, S_XH, S_XUPD, S_SETTLE, S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -66'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/sca_div.sv -----
`default_nettype none
module sca_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire sca_pkg::div_req_t         req,
  output logic                           done,
  output logic [sca_pkg::DIV_NW-1:0]     quo
);
  import sca_pkg::*;

  logic [DIV_NW-1:0] num;
  logic [DIV_DW-1:0] den;
  logic [DIV_DW:0]   rem;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   diff;
  logic              ge;

  assign shifted = {rem[DIV_DW-1:0], num[DIV_NW-1]};
  assign ge      = shifted >= {1'b0, den};
  assign diff    = shifted - {1'b0, den};
  assign quo     = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        num  <= req.num;
        den  <= req.den;
        rem  <= '0;
        cnt  <= DIV_CW'(DIV_NW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff : shifted;
        num <= {num[DIV_NW-2:0], ge};
        cnt <= cnt - DIV_CW'(1);
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/spring_channel_animator.sv -----
// Spring channel animator: one channel pulled toward a goal by a damped spring.
// Input channel (in_valid/in_stall) carries cmd, value, dt_us and snap; a
// transfer happens when in_valid is high and in_stall is low. Each input
// transfer yields exactly one output transfer (out_valid/out_stall) carrying
// position, speed, running, settled_now and moved.
// Non-tick commands and idle or zero ticks go straight to the done state. A
// running tick first does its setup (a reciprocal multiply for the substep
// count and a divide for the substep length), then runs its substeps, each
// waiting on the bit-serial divider that forms the acceleration, and then
// posts the result; the multiplier is shared.
// in_stall is high while an item is in work. The output register holds a
// result until taken; while the receiver stalls a full output, the next item
// is still accepted but its result waits in the final state.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready.
// Synchronous reset restores the default spring constants and clears the
// position, velocity, goal and running flag.
`default_nettype none
module spring_channel_animator #(
  parameter int SUBSTEP_US = sca_pkg::SUBSTEP_US_DEF,
  parameter int MAX_DT_US  = sca_pkg::MAX_DT_US_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  cmd,
  input  wire logic [31:0] value,
  input  wire logic [23:0] dt_us,
  input  wire logic        snap,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      position,
  output logic [31:0]      speed,
  output logic             running,
  output logic             settled_now,
  output logic             moved,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import sca_pkg::*;

  localparam int DT_W  = $clog2(MAX_DT_US + 1);
  localparam int CNT_W = $clog2((MAX_DT_US + SUBSTEP_US - 1) / SUBSTEP_US + 1);
  localparam int CNT_NW = $clog2(MAX_DT_US + SUBSTEP_US);
  localparam int CNT_SH = CNT_NW + $clog2(SUBSTEP_US);
  localparam longint CNT_RECIP =
    ((longint'(1) << CNT_SH) + longint'(SUBSTEP_US) - 1) / longint'(SUBSTEP_US);

  state_t state, state_next;

  logic [30:0] mass, stiff, damp, vlim, peps, veps;
  logic [31:0] start_vel;

  logic [31:0] pos, vel, goal, start_pos;
  logic        busy, done_f, tick_run;

  logic [DT_W-1:0]  dts;
  logic [CNT_W-1:0] count, iter;
  logic [31:0]      hq;
  logic [46:0]      ke;
  logic             fneg;
  logic [62:0]      am, phi;

  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;
  div_req_t    dreq;
  logic        ddone;
  logic [DIV_NW-1:0] dquo;

  logic               accept;
  logic               out_free;
  logic [DT_W-1:0]    dts_in;
  logic signed [32:0] err;
  logic [32:0]        err_mag;
  logic [31:0]        vmag;
  logic [46:0]        cv;
  logic signed [48:0] fs;
  logic [47:0]        fm;
  logic [30:0]        mass_f;
  logic [63:0]        inc;
  logic signed [65:0] vsum, psum;
  logic [31:0]        vsat;
  logic signed [31:0] lim;
  logic [31:0]        vclamp;
  logic signed [32:0] perr;
  logic [32:0]        perr_mag;
  logic               settle;
  logic               last;

  sca_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .quo  (dquo)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign dts_in  = ({8'b0, dt_us} > 32'(MAX_DT_US)) ? DT_W'(MAX_DT_US) : DT_W'(dt_us);
  assign err     = {pos[31], pos} - {goal[31], goal};
  assign err_mag = err[32] ? 33'(-err) : 33'(err);
  assign vmag    = vel[31] ? (32'd0 - vel) : vel;
  assign cv      = prod[62:16];
  assign fs      = (err[32] ? $signed({2'b0, ke}) : -$signed({2'b0, ke}))
                 + (vel[31] ? $signed({2'b0, cv}) : -$signed({2'b0, cv}));
  assign fm      = fs[48] ? 48'(-fs) : 48'(fs);
  assign mass_f  = (mass < MASS_FLOOR) ? MASS_FLOOR : mass;

  assign inc    = {1'b0, phi} + {32'b0, prod[63:32]};
  assign vsum   = fneg ? ($signed({{34{vel[31]}}, vel}) - $signed({2'b0, inc}))
                       : ($signed({{34{vel[31]}}, vel}) + $signed({2'b0, inc}));
  assign vsat   = sat32(vsum);
  assign lim    = $signed({1'b0, vlim});
  always_comb begin
    vclamp = vsat;
    if (vlim != 31'd0) begin
      if ($signed(vsat) > lim) vclamp = lim;
      else if ($signed(vsat) < -lim) vclamp = 32'(-lim);
    end
  end
  assign psum = vel[31] ? ($signed({{34{pos[31]}}, pos}) - $signed({34'b0, prod[63:32]}))
                        : ($signed({{34{pos[31]}}, pos}) + $signed({34'b0, prod[63:32]}));

  assign perr     = {pos[31], pos} - {goal[31], goal};
  assign perr_mag = perr[32] ? 33'(-perr) : 33'(perr);
  assign settle   = (perr_mag <= {2'b0, peps}) && (vmag <= {1'b0, veps});
  assign last     = (iter + CNT_W'(1)) == count;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd == CMD_TICK && dt_us != 24'd0 && busy) state_next = S_CNT;
          else state_next = S_DONE;
        end
      end
      S_CNT:    state_next = S_CNTW;
      S_CNTW:   state_next = S_SCL;
      S_SCL:    state_next = S_HQ;
      S_HQ:     state_next = S_HQW;
      S_HQW:    if (ddone) state_next = S_KE;
      S_KE:     state_next = S_CV;
      S_CV:     state_next = S_F;
      S_F:      state_next = S_ADIV;
      S_ADIV:   if (ddone) state_next = S_AHH;
      S_AHH:    state_next = S_AHL;
      S_AHL:    state_next = S_VUPD;
      S_VUPD:   state_next = S_XH;
      S_XH:     state_next = S_XUPD;
      S_XUPD:   state_next = S_SETTLE;
      S_SETTLE: state_next = (settle || last) ? S_DONE : S_KE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = '0;
    case (state)
      S_CNT: begin
        mul_a = 33'(dts) + 33'(SUBSTEP_US - 1);
        mul_b = 33'(CNT_RECIP);
      end
      S_SCL: begin
        mul_a = 33'(count);
        mul_b = 33'(US_PER_S);
      end
      S_HQ: begin
        dreq.start = 1'b1;
        dreq.num   = DIV_NW'(dts) << 32;
        dreq.den   = prod[DIV_DW-1:0];
      end
      S_KE: begin
        mul_a = {2'b0, stiff};
        mul_b = err_mag;
      end
      S_CV: begin
        mul_a = {2'b0, damp};
        mul_b = {1'b0, vmag};
      end
      S_F: begin
        dreq.start = 1'b1;
        dreq.num   = {2'b0, fm, 16'b0};
        dreq.den   = {17'b0, mass_f};
      end
      S_AHH: begin
        mul_a = {2'b0, am[62:32]};
        mul_b = {1'b0, hq};
      end
      S_AHL: begin
        mul_a = {1'b0, am[31:0]};
        mul_b = {1'b0, hq};
      end
      S_XH: begin
        mul_a = {1'b0, vmag};
        mul_b = {1'b0, hq};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mass      <= 31'd65536;
      stiff     <= 31'd6553600;
      damp      <= 31'd1310720;
      vlim      <= 31'd0;
      peps      <= 31'd66;
      veps      <= 31'd66;
      start_vel <= 32'd0;
      pos       <= 32'd0;
      vel       <= 32'd0;
      goal      <= 32'd0;
      busy      <= 1'b0;
      done_f    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MASS:      mass      <= cfg_data[30:0];
          REG_STIFFNESS: stiff     <= cfg_data[30:0];
          REG_DAMPING:   damp      <= cfg_data[30:0];
          REG_VLIMIT:    vlim      <= cfg_data[30:0];
          REG_POS_EPS:   peps      <= cfg_data[30:0];
          REG_VEL_EPS:   veps      <= cfg_data[30:0];
          REG_START_VEL: start_vel <= cfg_data;
          default: begin
          end
        endcase
      end

      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept) begin
            done_f    <= 1'b0;
            tick_run  <= (cmd == CMD_TICK);
            start_pos <= pos;
            dts       <= dts_in;
            iter      <= '0;
            case (cmd)
              CMD_ANIMATE: begin
                goal <= value;
                if (snap) begin
                  pos  <= value;
                  vel  <= 32'd0;
                  busy <= 1'b0;
                end else begin
                  if (!busy) vel <= start_vel;
                  busy <= 1'b1;
                end
              end
              CMD_RETARGET: begin
                goal <= value;
                busy <= 1'b1;
              end
              CMD_SET: begin
                pos  <= value;
                goal <= value;
                vel  <= 32'd0;
                busy <= 1'b0;
              end
              CMD_STOP: begin
                if (snap) pos <= goal;
                vel  <= 32'd0;
                busy <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_CNTW:   count <= CNT_W'(prod >> CNT_SH);
        S_HQW:    if (ddone) hq <= dquo[31:0];
        S_CV:     ke <= prod[62:16];
        S_F:      fneg <= fs[48];
        S_ADIV:   if (ddone) am <= (dquo > ACC_CAP) ? ACC_CAP[62:0] : dquo[62:0];
        S_AHL:    phi <= prod[62:0];
        S_VUPD:   vel <= vclamp;
        S_XUPD:   pos <= sat32(psum);
        S_SETTLE: begin
          iter <= iter + CNT_W'(1);
          if (settle) begin
            pos    <= goal;
            vel    <= 32'd0;
            busy   <= 1'b0;
            done_f <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            position    <= pos;
            speed       <= vel;
            running     <= busy;
            settled_now <= done_f;
            moved       <= tick_run && (done_f || (pos != start_pos));
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sim/spring_channel_animator_check.sv -----
`timescale 1ns / 100ps
`default_nettype none
module spring_channel_animator_check
  import sca_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [2:0]  cmd,
  input  wire logic [31:0] value,
  input  wire logic [23:0] dt_us,
  input  wire logic        snap,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] position,
  input  wire logic [31:0] speed,
  input  wire logic        running,
  input  wire logic        settled_now,
  input  wire logic        moved,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               n_checked,
  output int               n_fail
);

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] spd;
    logic        run;
    logic        settled;
    logic        mov;
  } motion_t;

  motion_t motion_q[$];

  longint unsigned mass_r, stiff_r, damp_r, vlim_r, peps_r, veps_r;
  longint start_vel_r;
  longint pos_s, vel_s, goal_s;
  bit busy_s;

  function automatic longint unsigned magn(input longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint apply_sign(input longint unsigned m, input bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned times_h(input longint unsigned m,
                                              input longint unsigned hq);
    return (m >> 32) * hq + (((m & 64'hFFFF_FFFF) * hq) >> 32);
  endfunction

  function automatic bit spring_substep(input longint unsigned hq);
    longint err, f;
    longint unsigned ke, cv, fm, mm, q, r, am;
    err = pos_s - goal_s;
    ke = (stiff_r * magn(err)) >> 16;
    cv = (damp_r * magn(vel_s)) >> 16;
    f = -apply_sign(ke, err < 0) - apply_sign(cv, vel_s < 0);
    fm = magn(f);
    mm = (mass_r < 64'(MASS_FLOOR)) ? 64'(MASS_FLOOR) : mass_r;
    q = fm / mm;
    r = fm % mm;
    if (q >= (64'd1 << 46)) am = 64'd1 << 62;
    else begin
      am = (q << 16) + ((r << 16) / mm);
      if (am > (64'd1 << 62)) am = 64'd1 << 62;
    end
    vel_s = clip32(vel_s + apply_sign(times_h(am, hq), f < 0));
    if (vlim_r != 0) begin
      if (vel_s > longint'(vlim_r)) vel_s = longint'(vlim_r);
      if (vel_s < -longint'(vlim_r)) vel_s = -longint'(vlim_r);
    end
    pos_s = clip32(pos_s + apply_sign(times_h(magn(vel_s), hq), vel_s < 0));
    if (magn(pos_s - goal_s) <= peps_r && magn(vel_s) <= veps_r) begin
      pos_s = goal_s;
      vel_s = 0;
      busy_s = 0;
      return 1;
    end
    return 0;
  endfunction

  function automatic motion_t predict_motion(input logic [2:0] c, input logic [31:0] v,
                                             input logic [23:0] d, input logic s);
    motion_t res;
    longint val, start_pos;
    longint unsigned dts, cnt, hq;
    bit done, mov;
    val = longint'(signed'(v));
    done = 0;
    mov = 0;
    case (c)
      CMD_TICK: begin
        if (d != 0 && busy_s) begin
          dts = (d > MAX_DT_US_DEF) ? 64'(MAX_DT_US_DEF) : 64'(d);
          cnt = (dts + SUBSTEP_US_DEF - 1) / SUBSTEP_US_DEF;
          if (cnt == 0) cnt = 1;
          hq = (dts << 32) / (cnt * US_PER_S);
          start_pos = pos_s;
          for (longint unsigned i = 0; i < cnt && busy_s; i++) done = spring_substep(hq);
          mov = done || pos_s != start_pos;
        end
      end
      CMD_ANIMATE: begin
        goal_s = val;
        if (s) begin
          pos_s = val;
          vel_s = 0;
          busy_s = 0;
        end else begin
          if (!busy_s) vel_s = start_vel_r;
          busy_s = 1;
        end
      end
      CMD_RETARGET: begin
        goal_s = val;
        busy_s = 1;
      end
      CMD_SET: begin
        pos_s = val;
        goal_s = val;
        vel_s = 0;
        busy_s = 0;
      end
      CMD_STOP: begin
        if (s) pos_s = goal_s;
        vel_s = 0;
        busy_s = 0;
      end
      default: ;
    endcase
    res.pos = pos_s[31:0];
    res.spd = vel_s[31:0];
    res.run = busy_s;
    res.settled = done;
    res.mov = mov;
    return res;
  endfunction

  always @(posedge clk) begin
    motion_t want;
    if (rst) begin
      mass_r <= 65536;
      stiff_r <= 6553600;
      damp_r <= 1310720;
      vlim_r <= 0;
      peps_r <= 66;
      veps_r <= 66;
      start_vel_r <= 0;
      pos_s <= 0;
      vel_s <= 0;
      goal_s <= 0;
      busy_s <= 0;
      motion_q.delete();
      n_checked <= 0;
      n_fail <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (motion_q.size() == 0) begin
          $error("unexpected result transfer");
          n_fail++;
        end else begin
          want = motion_q.pop_front();
          if (position !== want.pos) begin
            $error("position expected %h actual %h", want.pos, position);
            n_fail++;
          end
          if (speed !== want.spd) begin
            $error("speed expected %h actual %h", want.spd, speed);
            n_fail++;
          end
          if (running !== want.run) begin
            $error("running expected %b actual %b", want.run, running);
            n_fail++;
          end
          if (settled_now !== want.settled) begin
            $error("settled_now expected %b actual %b", want.settled, settled_now);
            n_fail++;
          end
          if (moved !== want.mov) begin
            $error("moved expected %b actual %b", want.mov, moved);
            n_fail++;
          end
          n_checked++;
        end
      end
      if (in_valid && !in_stall)
        motion_q = {motion_q, predict_motion(cmd, value, dt_us, snap)};
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MASS:      mass_r = cfg_data[30:0];
          REG_STIFFNESS: stiff_r = cfg_data[30:0];
          REG_DAMPING:   damp_r = cfg_data[30:0];
          REG_VLIMIT:    vlim_r = cfg_data[30:0];
          REG_POS_EPS:   peps_r = cfg_data[30:0];
          REG_VEL_EPS:   veps_r = cfg_data[30:0];
          REG_START_VEL: start_vel_r = longint'(signed'(cfg_data));
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- sim/spring_channel_animator_test.sv -----
`timescale 1ns / 100ps
`default_nettype none
module spring_channel_animator_test;
  import sca_pkg::*;

  localparam int CYCLE_LIMIT = 30000000;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 272;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] cmd = CMD_TICK;
  logic [31:0] value = '0;
  logic [23:0] dt_us = '0;
  logic snap = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] position, speed;
  logic running, settled_now, moved;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_MASS;
  logic [31:0] cfg_data = '0;

  int n_checked, n_fail;
  int n_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int cycles = 0;

  logic [31:0] spring_cfg [PHASES][7] = '{
    '{32'd65536, 32'd6553600, 32'd1310720, 32'd0, 32'd66, 32'd66, 32'd0},
    '{32'd1, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000},
    '{32'h7FFF_FFFF, 32'd262144, 32'd262144, 32'd655360, 32'd655, 32'd655, 32'd196608},
    '{32'd65536, 32'd26214400, 32'd0, 32'd655360, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      32'h7FFF_FFFF},
    '{32'd32768, 32'd3276800, 32'd655360, 32'h7FFF_FFFF, 32'd1, 32'd1, -32'sd327680},
    '{32'd131072, 32'd1966080, 32'd393216, 32'd13107200, 32'd300, 32'd300, 32'd655360}
  };

  spring_channel_animator dut (.*);

  spring_channel_animator_check checker_i (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("spring_channel_animator_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic push_item(input logic [2:0] c, input logic [31:0] v,
                           input logic [23:0] d, input logic s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    value <= v;
    dt_us <= d;
    snap <= s;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (n_checked != n_sent);
  endtask

  task automatic load_spring(input int ph);
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= spring_cfg[ph][i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item;
    logic [2:0] c;
    logic [31:0] v;
    logic [23:0] d;
    int pick;
    pick = $urandom_range(99);
    if (pick < 58) c = CMD_TICK;
    else if (pick < 74) c = CMD_ANIMATE;
    else if (pick < 83) c = CMD_RETARGET;
    else if (pick < 89) c = CMD_SET;
    else if (pick < 97) c = CMD_STOP;
    else c = 3'($urandom_range(5, 7));
    if ($urandom_range(1)) v = $urandom;
    else v = 32'($urandom_range(0, 600 * 65536)) - 32'(300 * 65536);
    pick = $urandom_range(999);
    if (pick < 3) d = 24'($urandom);
    else if (pick < 30) d = '0;
    else if (pick < 130) d = 24'($urandom_range(1, 200000));
    else d = 24'($urandom_range(1, 40000));
    push_item(c, v, d, ($urandom_range(4) == 0));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_item(CMD_TICK, 32'h7FFF_FFFF, 24'd16667, 1'b1);
    push_item(CMD_ANIMATE, 32'd6553600, 24'hFFFFFF, 1'b0);
    push_item(CMD_TICK, 32'h8000_0000, 24'd0, 1'b1);
    push_item(CMD_TICK, 32'd0, 24'd1, 1'b0);
    push_item(CMD_TICK, 32'd0, 24'd16667, 1'b0);
    push_item(CMD_ANIMATE, -32'sd3276800, 24'd0, 1'b0);
    push_item(CMD_RETARGET, 32'h8000_0000, 24'd0, 1'b1);
    push_item(CMD_TICK, 32'd0, 24'd33333, 1'b0);
    push_item(CMD_TICK, 32'd0, 24'd10000000, 1'b0);
    push_item(CMD_ANIMATE, 32'h7FFF_FFFF, 24'd0, 1'b0);
    push_item(CMD_TICK, 32'd0, 24'hFFFFFF, 1'b0);
    push_item(CMD_SET, 32'h8000_0000, 24'hFFFFFF, 1'b1);
    push_item(CMD_ANIMATE, 32'd655360, 24'd0, 1'b1);
    push_item(CMD_RETARGET, 32'd0, 24'd0, 1'b0);
    push_item(CMD_TICK, 32'd0, 24'd8000, 1'b0);
    push_item(CMD_STOP, 32'hFFFF_FFFF, 24'hFFFFFF, 1'b1);
    push_item(CMD_RETARGET, 32'd1310720, 24'd0, 1'b0);
    push_item(CMD_TICK, 32'd0, 24'd4167, 1'b0);
    push_item(CMD_STOP, 32'd0, 24'd0, 1'b0);
    for (int c = 5; c < 8; c++) push_item(3'(c), 32'h5A5A_A5A5, 24'h5A5A5A, 1'b1);
    push_item(CMD_TICK, 32'd0, 24'd4168, 1'b0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      load_spring(ph);
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 68; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 68; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      if (ph == 2) hold_cycles = 3000;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item();
      drain();
    end

    repeat (20) @(posedge clk);
    if (n_fail == 0) $display("spring_channel_animator_test: PASS");
    else $display("spring_channel_animator_test: FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
hdl/sca_pkg.sv
hdl/sca_div.sv
hdl/spring_channel_animator.sv
sim/spring_channel_animator_check.sv
sim/spring_channel_animator_test.sv
